[src/ros_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering package
// Shared types and fixed constants: payload structs, configuration
// register layout and the gray conversion coefficients.
// ----------------------------------------------------------------------------
package ros_pkg;

  localparam int COUNT_W    = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GRAY_W     = 23;
  localparam int GRAY_SHIFT = 14;
  localparam int FACTOR_W   = 9;
  localparam int STEP_W     = 15;
  localparam int ANGLE_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 14'h3FFF;

  localparam logic [GRAY_W-1:0] GRAY_B_COEF = 23'd1868;
  localparam logic [GRAY_W-1:0] GRAY_G_COEF = 23'd9617;
  localparam logic [GRAY_W-1:0] GRAY_R_COEF = 23'd4899;
  localparam logic [GRAY_W-1:0] GRAY_ROUND  = 23'd8192;

  localparam logic [CFG_IDX_W-1:0] REG_STRIP_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP      = 3'd4;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        frame_end;
  } pix_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] steer_angle;
    logic [2:0]                chosen_strip;
    logic                      speed_fast;
  } res_t;

  typedef struct packed {
    logic [3:0]                strip_count;
    logic [7:0]                region_width;
    logic [FACTOR_W-1:0]       discount_factor;
    logic signed [ANGLE_W-1:0] min_angle;
    logic [STEP_W-1:0]         angle_step;
  } cfg_t;

endpackage

[src/region_occupancy_steering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering
// Counts occupied pixels in vertical strips of a frame and, at the end of
// each frame, picks the least occupied strip and reports a steering angle.
//
// Pixels enter on the in channel (valid/ready), one transfer per pixel, with
// frame_end set on the last pixel of a frame. Ordinary pixels are taken at
// one per cycle while the queue has room. A frame_end pixel produces one
// result on the out channel (valid/ready); the back end scans one strip
// counter per cycle and does not take from its queue until the result is
// emitted, so the pixel stream stalls once the four-entry queue fills.
// Other pixels produce no result. The configuration port writes one register
// per cycle with cfg_we_i; the user must use it only while the block is idle,
// which the block itself does not enforce. Reset clears all counters,
// empties the queue and loads the register defaults. When the receiver
// stalls, the result waits in the output register, the queue fills and
// in_ready_o drops.
module region_occupancy_steering #(
  parameter int MAX_STRIPS   = 8,
  parameter int STRIP_ROWS   = 90,
  parameter int SPAN_COLUMNS = 160
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ros_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ros_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ros_pkg::pix_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ros_pkg::res_t                      out_data_o
);
  import ros_pkg::*;

  localparam int IDX_W = $clog2(MAX_STRIPS);
  localparam int Q_W   = IDX_W + 2;

  cfg_t           cfg_q;
  logic           f_valid;
  logic           f_ready;
  logic [Q_W-1:0] f_data;
  logic           b_valid;
  logic           b_ready;
  logic [Q_W-1:0] b_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strip_count     <= 4'd3;
      cfg_q.region_width    <= 8'd53;
      cfg_q.discount_factor <= 9'd218;
      cfg_q.min_angle       <= -16'sd5734;
      cfg_q.angle_step      <= 15'd5734;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STRIP_COUNT:     cfg_q.strip_count     <= cfg_wdata_i[3:0];
        REG_REGION_WIDTH:    cfg_q.region_width    <= cfg_wdata_i[7:0];
        REG_DISCOUNT_FACTOR: cfg_q.discount_factor <= cfg_wdata_i[FACTOR_W-1:0];
        REG_MIN_ANGLE:       cfg_q.min_angle       <= $signed(cfg_wdata_i);
        REG_ANGLE_STEP:      cfg_q.angle_step      <= cfg_wdata_i[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ros_front #(
    .MAX_STRIPS  (MAX_STRIPS),
    .STRIP_ROWS  (STRIP_ROWS),
    .SPAN_COLUMNS(SPAN_COLUMNS),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_data_o  (f_data)
  );

  ros_queue #(
    .DATA_W(Q_W),
    .DEPTH (4)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  (f_data),
    .out_valid_o(b_valid),
    .out_ready_i(b_ready),
    .out_data_o (b_data)
  );

  ros_back #(
    .MAX_STRIPS(MAX_STRIPS),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (b_valid),
    .q_ready_o  (b_ready),
    .q_data_i   (b_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

[src/ros_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering front end
// Registers each pixel with its occupancy flag, then finds the strip it
// falls in and pushes one entry per pixel into the work queue.
// ----------------------------------------------------------------------------
module ros_front #(
  parameter int MAX_STRIPS   = 8,
  parameter int STRIP_ROWS   = 90,
  parameter int SPAN_COLUMNS = 160,
  parameter int IDX_W        = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ros_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ros_pkg::pix_t       in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output logic [IDX_W+1:0]    q_data_o
);
  import ros_pkg::*;

  localparam int NUM_W = $clog2(MAX_STRIPS + 1);
  localparam int LIM_W = 8 + NUM_W;

  logic              s1_v_q;
  logic              gray_nz_q;
  logic [11:0]       x_q;
  logic [11:0]       y_q;
  logic              last_q;
  logic [GRAY_W-1:0] gray_sum;
  logic [NUM_W-1:0]  n_use;
  logic [NUM_W-1:0]  below;
  logic [LIM_W-1:0]  lim;
  logic              hit;
  logic [IDX_W-1:0]  strip;

  assign gray_sum = GRAY_W'(in_data_i.blue) * GRAY_B_COEF
                  + GRAY_W'(in_data_i.green) * GRAY_G_COEF
                  + GRAY_W'(in_data_i.red) * GRAY_R_COEF
                  + GRAY_ROUND;

  assign in_ready_o = !s1_v_q || q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      gray_nz_q <= gray_sum[GRAY_W-1:GRAY_SHIFT] != '0;
      x_q       <= in_data_i.pixel_x;
      y_q       <= in_data_i.pixel_y;
      last_q    <= in_data_i.frame_end;
    end
  end

  always_comb begin
    if (cfg_i.strip_count == '0) begin
      n_use = NUM_W'(1);
    end else if (32'(cfg_i.strip_count) > 32'(MAX_STRIPS)) begin
      n_use = NUM_W'(MAX_STRIPS);
    end else begin
      n_use = NUM_W'(cfg_i.strip_count);
    end
  end

  always_comb begin
    below = '0;
    lim   = '0;
    for (int i = 0; i < MAX_STRIPS; i++) begin
      lim   = LIM_W'(i + 1) * LIM_W'(cfg_i.region_width);
      below = below + NUM_W'(lim <= LIM_W'(x_q));
    end
  end

  assign hit = gray_nz_q && (cfg_i.region_width != '0)
            && (32'(y_q) < 32'(STRIP_ROWS)) && (32'(x_q) < 32'(SPAN_COLUMNS))
            && (below < n_use);
  assign strip = IDX_W'(below);

  assign q_valid_o = s1_v_q;
  assign q_data_o  = {last_q, hit, strip};

endmodule

[src/ros_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering work queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module ros_queue #(
  parameter int DATA_W = 5,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push;
  logic              pop;

  assign in_ready_o  = cnt_q != CNT_W'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

[src/ros_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering back end
// Updates the strip counters, and at the end of a frame scans them for the
// least discounted count, forms the steering angle and clears the counters.
// ----------------------------------------------------------------------------
module ros_back #(
  parameter int MAX_STRIPS = 8,
  parameter int IDX_W      = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ros_pkg::cfg_t    cfg_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  logic [IDX_W+1:0] q_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ros_pkg::res_t    out_data_o
);
  import ros_pkg::*;

  localparam int NUM_W  = $clog2(MAX_STRIPS + 1);
  localparam int SCAL_W = COUNT_W + FACTOR_W;
  localparam int VAL_W  = SCAL_W - 8;
  localparam int PA_W   = STEP_W + IDX_W;
  localparam int SUM_W  = PA_W + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_ANGLE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-32768);

  logic [1:0]               state_q;
  logic [1:0]               state_d;
  logic [COUNT_W-1:0]       counts_q [MAX_STRIPS];
  logic [IDX_W-1:0]         idx_q;
  logic [IDX_W-1:0]         best_q;
  logic [VAL_W-1:0]         best_val_q;
  logic [PA_W-1:0]          prod_q;
  logic                     out_v_q;
  res_t                     out_q;
  logic [NUM_W-1:0]         n_use;
  logic                     pop;
  logic                     q_last;
  logic                     q_hit;
  logic [IDX_W-1:0]         q_strip;
  logic [COUNT_W-1:0]       cur;
  logic [SCAL_W-1:0]        scaled;
  logic [VAL_W-1:0]         val;
  logic                     take;
  logic                     scan_end;
  logic                     emit;
  logic signed [SUM_W-1:0]  sum_s;
  logic signed [SUM_W-1:0]  neg_s;
  logic signed [ANGLE_W-1:0] angle;

  always_comb begin
    if (cfg_i.strip_count == '0) begin
      n_use = NUM_W'(1);
    end else if (32'(cfg_i.strip_count) > 32'(MAX_STRIPS)) begin
      n_use = NUM_W'(MAX_STRIPS);
    end else begin
      n_use = NUM_W'(cfg_i.strip_count);
    end
  end

  assign q_last    = q_data_i[IDX_W+1];
  assign q_hit     = q_data_i[IDX_W];
  assign q_strip   = q_data_i[IDX_W-1:0];
  assign q_ready_o = state_q == ST_IDLE;
  assign pop       = q_valid_i && q_ready_o;

  assign cur      = counts_q[idx_q];
  assign scaled   = SCAL_W'(cur) * SCAL_W'(cfg_i.discount_factor);
  assign val      = (NUM_W'(idx_q) == (n_use >> 1)) ? scaled[SCAL_W-1:8] : VAL_W'(cur);
  assign take     = (idx_q == '0) || (val < best_val_q);
  assign scan_end = NUM_W'(idx_q) == n_use - 1'b1;
  assign emit     = (state_q == ST_EMIT) && (!out_v_q || out_ready_i);

  assign sum_s = SUM_W'(cfg_i.min_angle) + $signed(SUM_W'(prod_q));
  assign neg_s = -sum_s;

  always_comb begin
    if (neg_s > SAT_HI) begin
      angle = 16'sh7FFF;
    end else if (neg_s < SAT_LO) begin
      angle = 16'sh8000;
    end else begin
      angle = neg_s[ANGLE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop && q_last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
      idx_q   <= '0;
      for (int i = 0; i < MAX_STRIPS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (pop && q_hit && counts_q[q_strip] != COUNT_MAX) begin
        counts_q[q_strip] <= counts_q[q_strip] + 1'b1;
      end
      if (emit) begin
        for (int i = 0; i < MAX_STRIPS; i++) begin
          counts_q[i] <= '0;
        end
      end
      if (state_q == ST_SCAN) begin
        idx_q <= scan_end ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && take) begin
      best_q     <= idx_q;
      best_val_q <= val;
    end
    if (state_q == ST_ANGLE) begin
      prod_q <= PA_W'(cfg_i.angle_step) * PA_W'(best_q);
    end
    if (emit) begin
      out_q.steer_angle  <= angle;
      out_q.chosen_strip <= 3'(best_q);
      out_q.speed_fast   <= angle == '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[tb/region_occupancy_steering_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region occupancy steering testbench
// Streams pixel frames into the block under random input gaps and output
// stalls, tracks the strip counters and configuration in a local predictor,
// and checks every steering result against the predicted one in order.
// Covers reset defaults, field extremes and many random configurations
// with short random frames.
// ----------------------------------------------------------------------------
module region_occupancy_steering_test;
  import ros_pkg::*;

  localparam int MAX_STRIPS   = 8;
  localparam int STRIP_ROWS   = 90;
  localparam int SPAN_COLUMNS = 160;
  localparam int CFG_SLOTS    = 1 << CFG_IDX_W;
  localparam int SETTLE_CYCLES = MAX_STRIPS + 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pix_t                  in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  res_t                  out_data_o;

  logic [COUNT_W-1:0]        occ_count [MAX_STRIPS];
  logic [3:0]                nreg_cfg;
  logic [7:0]                width_cfg;
  logic [FACTOR_W-1:0]       factor_cfg;
  logic signed [ANGLE_W-1:0] base_angle_cfg;
  logic [STEP_W-1:0]         step_cfg;

  res_t expected_steer [$];

  bit in_calm;
  bit out_calm;
  int unsigned mismatches;
  int unsigned frames_checked;
  int unsigned pixels_sent;
  int unsigned cfg_writes;
  int unsigned phases;

  region_occupancy_steering #(
    .MAX_STRIPS  (MAX_STRIPS),
    .STRIP_ROWS  (STRIP_ROWS),
    .SPAN_COLUMNS(SPAN_COLUMNS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(4_000_000);
    $display("Timed out with %0d results still pending.", expected_steer.size());
    $display("region_occupancy_steering_test: FAIL");
    $finish;
  end

  task automatic reset_model();
    for (int i = 0; i < MAX_STRIPS; i++) occ_count[i] = '0;
    nreg_cfg       = 4'd3;
    width_cfg      = 8'd53;
    factor_cfg     = 9'd218;
    base_angle_cfg = -16'sd5734;
    step_cfg       = 15'd5734;
  endtask

  function automatic int unsigned strips_used();
    if (nreg_cfg < 1) return 1;
    if (nreg_cfg > MAX_STRIPS) return MAX_STRIPS;
    return nreg_cfg;
  endfunction

  // Updates the strip counters for one accepted pixel and, on the last pixel
  // of a frame, queues the steering result and clears the counters.
  task automatic track_pixel(input pix_t p);
    int unsigned gray;
    int unsigned n;
    int unsigned s;
    int unsigned best;
    int unsigned best_val;
    int unsigned v;
    int angle;
    res_t r;
    n = strips_used();
    gray = (int'(p.blue) * int'(GRAY_B_COEF) + int'(p.green) * int'(GRAY_G_COEF) +
            int'(p.red) * int'(GRAY_R_COEF) + int'(GRAY_ROUND)) >> GRAY_SHIFT;
    if (gray != 0 && width_cfg != 0 && p.pixel_y < STRIP_ROWS &&
        p.pixel_x < SPAN_COLUMNS) begin
      s = p.pixel_x / width_cfg;
      if (s < n && occ_count[s] < COUNT_MAX) occ_count[s]++;
    end
    if (!p.frame_end) return;
    best = 0;
    best_val = 32'hFFFF_FFFF;
    for (int unsigned i = 0; i < n; i++) begin
      v = occ_count[i];
      if (i == n / 2) v = (v * factor_cfg) >> 8;
      if (v < best_val) begin
        best_val = v;
        best = i;
      end
    end
    angle = -(int'(base_angle_cfg) + int'(step_cfg) * int'(best));
    if (angle > 32767) angle = 32767;
    if (angle < -32768) angle = -32768;
    r.steer_angle  = 16'(angle);
    r.chosen_strip = 3'(best);
    r.speed_fast   = (angle == 0);
    expected_steer.insert(expected_steer.size(), r);
    for (int i = 0; i < MAX_STRIPS; i++) occ_count[i] = '0;
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val, input int unsigned w);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] word;
    mask = CFG_DATA_W'((32'd1 << w) - 1);
    word = (CFG_DATA_W'($urandom) & ~mask) | (val & mask);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= word;
    case (idx)
      REG_STRIP_COUNT:     nreg_cfg = word[3:0];
      REG_REGION_WIDTH:    width_cfg = word[7:0];
      REG_DISCOUNT_FACTOR: factor_cfg = word[FACTOR_W-1:0];
      REG_MIN_ANGLE:       base_angle_cfg = word;
      REG_ANGLE_STEP:      step_cfg = word[STEP_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic load_config(input int nr, input int rw, input int df, input int ma,
                             input int st, input bit spare);
    write_reg(REG_STRIP_COUNT, CFG_DATA_W'(nr), 4);
    write_reg(REG_REGION_WIDTH, CFG_DATA_W'(rw), 8);
    write_reg(REG_DISCOUNT_FACTOR, CFG_DATA_W'(df), FACTOR_W);
    write_reg(REG_MIN_ANGLE, CFG_DATA_W'(ma), ANGLE_W);
    write_reg(REG_ANGLE_STEP, CFG_DATA_W'(st), STEP_W);
    if (spare) begin
      for (int k = int'(REG_ANGLE_STEP) + 1; k < CFG_SLOTS; k++)
        write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom), 0);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Waits for every pending result, then for the back end to drain.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_steer.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_pixel(input pix_t p);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    track_pixel(p);
    pixels_sent++;
  endtask

  function automatic pix_t pixel_of(input int x, input int y, input int b, input int g,
                                    input int r, input bit last);
    pix_t p;
    p.pixel_x   = 12'(x);
    p.pixel_y   = 12'(y);
    p.blue      = 8'(b);
    p.green     = 8'(g);
    p.red       = 8'(r);
    p.frame_end = last;
    return p;
  endfunction

  function automatic pix_t random_pixel(input bit last);
    pix_t p;
    int unsigned shade;
    if ($urandom_range(0, 15) == 0) begin
      p.pixel_x = 12'($urandom);
      p.pixel_y = 12'($urandom);
    end else begin
      p.pixel_x = 12'($urandom_range(0, SPAN_COLUMNS + 9));
      p.pixel_y = 12'($urandom_range(0, STRIP_ROWS + 2));
    end
    shade = $urandom_range(0, 3);
    case (shade)
      0: begin
        p.blue = '0; p.green = '0; p.red = '0;
      end
      1: begin
        p.blue  = 8'($urandom_range(0, 2));
        p.green = 8'($urandom_range(0, 2));
        p.red   = 8'($urandom_range(0, 2));
      end
      2: begin
        p.blue = 8'($urandom); p.green = 8'($urandom); p.red = 8'($urandom);
      end
      default: begin
        p.blue = 8'hFF; p.green = 8'hFF; p.red = 8'hFF;
      end
    endcase
    p.frame_end = last;
    return p;
  endfunction

  always @(posedge clk_i) begin : score_results
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_steer.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: angle %0d strip %0d fast %0b",
                   out_data_o.steer_angle, out_data_o.chosen_strip, out_data_o.speed_fast);
      end else begin
        want = expected_steer.pop_front();
        frames_checked++;
        if (out_data_o.steer_angle !== want.steer_angle ||
            out_data_o.chosen_strip !== want.chosen_strip ||
            out_data_o.speed_fast !== want.speed_fast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d (angle/strip/fast): expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     frames_checked, want.steer_angle, want.chosen_strip, want.speed_fast,
                     out_data_o.steer_angle, out_data_o.chosen_strip, out_data_o.speed_fast);
        end
      end
    end
  end

  initial begin : drain_results
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Three strips of 53 columns; column 159 lies past the last strip.
  task automatic test_reset_defaults();
    send_pixel(pixel_of(0, 0, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(52, 0, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(53, 89, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(159, 0, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(106, 0, 255, 255, 255, 1'b1));
  endtask

  task automatic test_field_extremes();
    settle_block();
    load_config(2, 80, 256, -32768, 0, 1'b1);
    send_pixel(pixel_of(4095, 0, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(0, 4095, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(0, 89, 0, 1, 0, 1'b0));
    send_pixel(pixel_of(79, 0, 2, 0, 1, 1'b0));
    send_pixel(pixel_of(80, 0, 1, 0, 1, 1'b0));
    send_pixel(pixel_of(159, 90, 255, 255, 255, 1'b0));
    send_pixel(pixel_of(159, 89, 255, 255, 255, 1'b1));
    settle_block();
    load_config(8, 20, 256, 32767, 32767, 1'b0);
    for (int i = 0; i < MAX_STRIPS - 1; i++)
      send_pixel(pixel_of(i * 20, 0, 255, 255, 255, i == MAX_STRIPS - 2));
    settle_block();
    load_config(0, 255, 511, 0, 0, 1'b0);
    send_pixel(pixel_of(0, 0, 255, 255, 255, 1'b1));
    settle_block();
    load_config(15, 0, 0, -5, 9, 1'b0);
    send_pixel(pixel_of(3, 3, 255, 255, 255, 1'b1));
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int nr;
    int rw;
    int df;
    int ma;
    int st;
    int unsigned frames;
    int unsigned len;
    pix_t p;
    while (pixels_sent < 800) begin
      settle_block();
      pick = $urandom_range(0, 9);
      if (pick < 8) nr = $urandom_range(2, 8);
      else if (pick == 8) nr = $urandom_range(0, 1);
      else nr = $urandom_range(9, 15);
      pick = $urandom_range(0, 9);
      if (pick < 6) rw = SPAN_COLUMNS / ((nr < 1) ? 1 : (nr > MAX_STRIPS) ? MAX_STRIPS : nr);
      else if (pick < 8) rw = $urandom_range(1, 160);
      else if (pick == 8) rw = 0;
      else rw = $urandom_range(161, 255);
      df = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
      if ($urandom_range(0, 3) == 0) begin
        st = $urandom_range(0, 4095);
        ma = -(st * int'($urandom_range(0, 7)));
      end else begin
        st = $urandom_range(0, 32767);
        ma = $urandom_range(0, 65535);
      end
      load_config(nr, rw, df, ma, st, $urandom_range(0, 7) == 0);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      phases++;
      frames = $urandom_range(2, 6);
      for (int f = 0; f < frames; f++) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          p = random_pixel(i == len - 1);
          send_pixel(p);
        end
      end
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    in_calm  = 1'b0;
    out_calm = 1'b0;
    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_steer.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d steering results from %0d pixel transfers and %0d register writes.",
             frames_checked, pixels_sent, cfg_writes);
    $display("Run covered reset defaults, field extremes and %0d random phases.",
             phases);
    if (mismatches == 0 && expected_steer.size() == 0) begin
      $display("region_occupancy_steering_test: PASS");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("region_occupancy_steering_test: FAIL");
    end
    $finish;
  end

endmodule
